@@ hdl/line_extent_of_projected_points_unit_defines.svh @@
// Assertion macros for the line extent block.
`ifndef LINE_EXTENT_OF_PROJECTED_POINTS_UNIT_DEFINES_SVH
`define LINE_EXTENT_OF_PROJECTED_POINTS_UNIT_DEFINES_SVH
// cond true at an edge implies prop at the same edge
`define LEPP_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// cond true at an edge implies prop at the next edge
`define LEPP_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

@@ hdl/lepp_pkg.sv @@
// Shared constants, types and state encodings of the line extent block.
`timescale 1ns / 1ps
`default_nettype none
package lepp_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int REG_COUNT       = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int DIR_MAG_W       = 31;  // magnitude of a Q2.30 unit component

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z  = 3'd5;

  typedef enum logic [2:0] {
    D_IDLE, D_LOAD, D_NORM, D_SQ, D_SQRT, D_DIVLOAD, D_DIV
  } dir_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_PROJ, B_PROJ_WAIT, B_FOLD, B_EXT, B_EXT_WAIT, B_EMIT
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic zero_length;
  } dir_status_t;
endpackage
`default_nettype wire

@@ hdl/lepp_if.sv @@
// Channel interfaces: point items, extent results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface lepp_item_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;
  logic                 last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface lepp_result_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] stop_x;
  logic signed [CW-1:0] stop_y;
  logic signed [CW-1:0] stop_z;
  logic                 degenerate;
  modport source (output valid, start_x, start_y, start_z, stop_x, stop_y, stop_z,
                  degenerate, input ready);
  modport sink   (input valid, start_x, start_y, start_z, stop_x, stop_y, stop_z,
                  degenerate, output ready);
endinterface

interface lepp_cfg_if #(parameter int CW = 32);
  import lepp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CW-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/line_extent_of_projected_points_unit.sv @@
// Line extent of projected points: top level.
//
// cfg writes the line: index 0..2 base x/y/z, 3..5 end x/y/z (signed Q16.16).
// Each write starts the direction solver (normalize, sum of squares, a
// 32-step square root, three 61-step divisions; only the load step when
// base equals end), during which cfg.ready and points.ready are
// low. Writes to other indexes are dropped.
// points carries one position per transaction; last_point closes a buffer.
// Each point takes three passes in the back part through the shared
// digit-serial multiplier; a queue of four lets the front keep taking
// points meanwhile. A point with last_point set adds
// six more multiplier passes, then one extent transaction (start = base +
// min*dir, stop = base + max*dir, degenerate) leaves through a register.
// A stalled extent holds in that register; the back part keeps working on
// queued points and waits only when the next extent is ready.
// Reset (rst, synchronous) clears the cfg registers to zero, the direction to
// zero and extent.valid; the extent data itself is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "line_extent_of_projected_points_unit_defines.svh"
module line_extent_of_projected_points_unit #(
  parameter int COORD_WIDTH = lepp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  lepp_cfg_if.sink      cfg,
  lepp_item_if.sink     points,
  lepp_result_if.source extent
);
  import lepp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int QW = 3 * (CW + 1) + 1;

  logic signed [CW-1:0]  base [3];
  logic [DIR_MAG_W-1:0]  dir_mag [3];
  logic                  dir_neg [3];
  dir_status_t           dir_stat;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_nonempty;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;

  lepp_dir #(.CW(CW)) u_dir (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .base    (base),
    .dir_mag (dir_mag),
    .dir_neg (dir_neg),
    .status  (dir_stat)
  );

  lepp_front #(.CW(CW)) u_front (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .base   (base),
    .hold   (dir_stat.busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  lepp_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  lepp_back #(.CW(CW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .base       (base),
    .dir_mag    (dir_mag),
    .dir_neg    (dir_neg),
    .dir_stat   (dir_stat),
    .extent     (extent)
  );

  `LEPP_ASSERT_NOW(a_no_point_while_solving, clk, rst, points.valid && points.ready, !dir_stat.busy)
  `LEPP_ASSERT_NEXT(a_write_starts_solver, clk, rst, cfg.valid && cfg.ready && (cfg.index <= REG_END_Z), dir_stat.busy)
  `LEPP_ASSERT_NOW(a_no_write_while_solving, clk, rst, dir_stat.busy, !cfg.ready)
endmodule
`default_nettype wire

@@ hdl/lepp_fifo.sv @@
// Short queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module lepp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              nonempty,
  output logic [W-1:0]      rdata
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hdl/lepp_dir.sv @@
// Configuration registers and the iterative unit-direction solver.
`timescale 1ns / 1ps
`default_nettype none
module lepp_dir #(
  parameter int CW = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  lepp_cfg_if.sink                           cfg,
  output logic signed [CW-1:0]               base [3],
  output logic [lepp_pkg::DIR_MAG_W-1:0]     dir_mag [3],
  output logic                               dir_neg [3],
  output lepp_pkg::dir_status_t              status
);
  import lepp_pkg::*;

  localparam int MW = CW + 1;
  localparam int NW = (MW > 31) ? MW : 31;

  dir_state_t state, state_next;

  logic [CW-1:0]  cfg_reg [REG_COUNT];
  logic           zero_len;
  logic [NW-1:0]  m [3];
  logic           neg [3];
  logic [NW-1:0]  mx;
  logic [1:0]     cnt;
  logic [59:0]    sq;
  logic [61:0]    s;
  logic [62:0]    x;
  logic [62:0]    r;
  logic [62:0]    b;
  logic [4:0]     k;
  logic [30:0]    n;
  logic [60:0]    num;
  logic [30:0]    rem;
  logic [29:0]    q;
  logic [5:0]     bitcnt;

  logic signed [MW-1:0] d [3];
  logic [MW-1:0]        dm [3];
  logic [MW-1:0]        dmax;
  logic [62:0]          trial;
  logic [31:0]          rem_sh;
  logic                 qbit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]  = {cfg_reg[int'(REG_END_X) + i][CW-1], cfg_reg[int'(REG_END_X) + i]}
            - {cfg_reg[int'(REG_BASE_X) + i][CW-1], cfg_reg[int'(REG_BASE_X) + i]};
      dm[i] = d[i][MW-1] ? MW'(-d[i]) : MW'(d[i]);
    end
    dmax = dm[0];
    if (dm[1] > dmax) dmax = dm[1];
    if (dm[2] > dmax) dmax = dm[2];
    trial  = r + b;
    rem_sh = {rem, num[60]};
    qbit   = (rem_sh >= {1'b0, n});
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base[i] = cfg_reg[int'(REG_BASE_X) + i];
    end
  end

  assign cfg.ready          = (state == D_IDLE);
  assign status.busy        = (state != D_IDLE);
  assign status.zero_length = zero_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: begin
        if (cfg.valid && cfg.index <= REG_END_Z) state_next = D_LOAD;
      end
      D_LOAD: begin
        state_next = (dmax == '0) ? D_IDLE : D_NORM;
      end
      D_NORM: begin
        if (!(|mx[NW-1:30]) && (|mx[NW-1:29])) state_next = D_SQ;
      end
      D_SQ: begin
        if (cnt == 2'd3) state_next = D_SQRT;
      end
      D_SQRT: begin
        if (k == 5'd31) state_next = D_DIVLOAD;
      end
      D_DIVLOAD: begin
        state_next = D_DIV;
      end
      D_DIV: begin
        if (bitcnt == 6'd0) state_next = (cnt == 2'd2) ? D_IDLE : D_DIVLOAD;
      end
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) cfg_reg[i] <= '0;
      for (int i = 0; i < 3; i++) begin
        dir_mag[i] <= '0;
        dir_neg[i] <= 1'b0;
      end
      zero_len <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          if (cfg.valid && cfg.index <= REG_END_Z) cfg_reg[cfg.index] <= cfg.data;
        end
        D_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            m[i]   <= NW'(dm[i]);
            neg[i] <= d[i][MW-1];
          end
          mx <= NW'(dmax);
          if (dmax == '0) begin
            zero_len <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              dir_mag[i] <= '0;
              dir_neg[i] <= 1'b0;
            end
          end else begin
            zero_len <= 1'b0;
          end
          cnt <= '0;
        end
        D_NORM: begin
          if (|mx[NW-1:30]) begin
            mx <= mx >> 1;
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else if (!(|mx[NW-1:29])) begin
            mx <= mx << 1;
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end
          cnt <= '0;
          s   <= '0;
        end
        D_SQ: begin
          if (cnt != 2'd3) sq <= m[cnt][29:0] * m[cnt][29:0];
          if (cnt != 2'd0) s <= s + 62'(sq);
          if (cnt == 2'd3) begin
            x <= 63'(s) + 63'(sq);
            r <= '0;
            b <= 63'(1) << 62;
            k <= '0;
          end
          cnt <= cnt + 1'b1;
        end
        D_SQRT: begin
          if (x >= trial) begin
            x <= x - trial;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
          k <= k + 1'b1;
          if (k == 5'd31) begin
            n   <= '0;
            cnt <= '0;
          end
        end
        D_DIVLOAD: begin
          // first pass through takes the finished root
          if (cnt == 2'd0 && n == '0) n <= r[30:0];
          num    <= {1'b0, m[cnt][29:0], 30'd0}
                  + 61'(((cnt == 2'd0 && n == '0) ? r[30:0] : n) >> 1);
          rem    <= '0;
          q      <= '0;
          bitcnt <= 6'd60;
        end
        D_DIV: begin
          rem    <= qbit ? 31'(rem_sh - {1'b0, n}) : rem_sh[30:0];
          q      <= {q[28:0], qbit};
          num    <= num << 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == 6'd0) begin
            dir_mag[cnt] <= {q, qbit};
            dir_neg[cnt] <= neg[cnt];
            cnt          <= cnt + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ hdl/lepp_front.sv @@
// Front part: takes point transactions, offsets them by the base point, tags the last one.
`timescale 1ns / 1ps
`default_nettype none
module lepp_front #(
  parameter int CW = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  lepp_item_if.sink               points,
  input  wire logic signed [CW-1:0] base [3],
  input  wire logic               hold,
  input  wire logic               q_full,
  output logic                    q_push,
  output logic [3*(CW+1):0]       q_data
);
  localparam int MW = CW + 1;

  logic                 stage_valid;
  logic signed [MW-1:0] v [3];
  logic                 last;

  assign q_push       = stage_valid && !q_full;
  assign points.ready = !hold && (!stage_valid || !q_full);
  assign q_data       = {last, v[2], v[1], v[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (points.valid && points.ready) begin
      stage_valid <= 1'b1;
    end else if (q_push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (points.valid && points.ready) begin
      v[0] <= {points.point_x[CW-1], points.point_x} - {base[0][CW-1], base[0]};
      v[1] <= {points.point_y[CW-1], points.point_y} - {base[1][CW-1], base[1]};
      v[2] <= {points.point_z[CW-1], points.point_z} - {base[2][CW-1], base[2]};
      last <= points.last_point;
    end
  end
endmodule
`default_nettype wire

@@ hdl/lepp_mul.sv @@
// Digit-serial signed multiply by a Q2.30 magnitude, rounded half away from zero.
`timescale 1ns / 1ps
`default_nettype none
module lepp_mul #(
  parameter int CW = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [CW:0]             a,
  input  wire logic [lepp_pkg::DIR_MAG_W-1:0] u_mag,
  input  wire logic                           u_neg,
  output logic                                done,
  output logic signed [CW+1:0]                res
);
  localparam int MW = CW + 1;
  localparam int PW = MW + 32;
  localparam int RW = MW + 1;

  logic          busy;
  logic [1:0]    cnt;
  logic [MW-1:0] ma;
  logic [31:0]   ud;
  logic          neg;
  logic [PW-1:0] acc;

  logic [MW+7:0] pp;
  logic [PW-1:0] rnd;

  always_comb begin
    pp  = {8'd0, ma} * {{MW{1'b0}}, ud[31:24]};
    rnd = (acc + (PW'(1) << 29)) >> 30;
    res = neg ? -RW'(rnd) : RW'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[MW-1] ? MW'(-a) : MW'(a);
      ud  <= {1'b0, u_mag};
      neg <= a[MW-1] ^ u_neg;
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << 8) + PW'(pp);
      ud  <= ud << 8;
    end
  end
endmodule
`default_nettype wire

@@ hdl/lepp_back.sv @@
// Back part: projects queued points, keeps the running extent, builds the endpoints.
`timescale 1ns / 1ps
`default_nettype none
module lepp_back #(
  parameter int CW = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_nonempty,
  input  wire logic [3*(CW+1):0]               q_data,
  output logic                                 q_pop,
  input  wire logic signed [CW-1:0]            base [3],
  input  wire logic [lepp_pkg::DIR_MAG_W-1:0]  dir_mag [3],
  input  wire logic                            dir_neg [3],
  input  wire lepp_pkg::dir_status_t           dir_stat,
  lepp_result_if.source                        extent
);
  import lepp_pkg::*;

  localparam int MW = CW + 1;
  localparam int RW = MW + 1;
  localparam int TW = RW + 2;
  localparam int EW = RW + 1;

  back_state_t state, state_next;

  logic signed [MW-1:0] v [3];
  logic                 last;
  logic [2:0]           idx;
  logic signed [TW-1:0] t_acc;
  logic signed [CW-1:0] least;
  logic signed [CW-1:0] greatest;
  logic signed [CW-1:0] ends [6];

  logic                 mul_start;
  logic                 mul_done;
  logic signed [MW-1:0] mul_a;
  logic signed [RW-1:0] mul_res;
  logic [1:0]           axis;
  logic signed [CW-1:0] t_sat;
  logic signed [EW-1:0] e_sum;
  logic signed [CW-1:0] e_sat;
  logic                 emit;

  always_comb begin
    axis = (idx >= 3'd3) ? 2'(idx - 3'd3) : idx[1:0];
    if (state == B_EXT) begin
      mul_a = (idx < 3'd3) ? {least[CW-1], least} : {greatest[CW-1], greatest};
    end else begin
      mul_a = v[axis];
    end
    if ((&t_acc[TW-1:CW-1]) || !(|t_acc[TW-1:CW-1])) begin
      t_sat = t_acc[CW-1:0];
    end else begin
      t_sat = t_acc[TW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    e_sum = {{(EW-CW){base[axis][CW-1]}}, base[axis]} + {mul_res[RW-1], mul_res};
    if ((&e_sum[EW-1:CW-1]) || !(|e_sum[EW-1:CW-1])) begin
      e_sat = e_sum[CW-1:0];
    end else begin
      e_sat = e_sum[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
  end

  lepp_mul #(.CW(CW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .u_mag (dir_mag[axis]),
    .u_neg (dir_neg[axis]),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    q_pop      = 1'b0;
    emit       = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_nonempty) begin
          q_pop      = 1'b1;
          state_next = B_PROJ;
        end
      end
      B_PROJ: begin
        mul_start  = 1'b1;
        state_next = B_PROJ_WAIT;
      end
      B_PROJ_WAIT: begin
        if (mul_done) state_next = (idx == 3'd2) ? B_FOLD : B_PROJ;
      end
      B_FOLD: begin
        state_next = last ? B_EXT : B_IDLE;
      end
      B_EXT: begin
        mul_start  = 1'b1;
        state_next = B_EXT_WAIT;
      end
      B_EXT_WAIT: begin
        if (mul_done) state_next = (idx == 3'd5) ? B_EMIT : B_EXT;
      end
      B_EMIT: begin
        if (!extent.valid || extent.ready) begin
          emit       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      least    <= '0;
      greatest <= '0;
    end else if (state == B_FOLD) begin
      if (t_sat > greatest) greatest <= t_sat;
      if (t_sat < least) least <= t_sat;
    end else if (emit) begin
      least    <= '0;
      greatest <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        v[0]  <= q_data[MW-1:0];
        v[1]  <= q_data[2*MW-1:MW];
        v[2]  <= q_data[3*MW-1:2*MW];
        last  <= q_data[3*MW];
        idx   <= '0;
        t_acc <= '0;
      end
      B_PROJ_WAIT: begin
        if (mul_done) begin
          t_acc <= t_acc + {{2{mul_res[RW-1]}}, mul_res};
          idx   <= idx + 1'b1;
        end
      end
      B_FOLD: begin
        idx <= '0;
      end
      B_EXT_WAIT: begin
        if (mul_done) begin
          ends[idx] <= e_sat;
          idx       <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extent.valid <= 1'b0;
    end else if (emit) begin
      extent.valid <= 1'b1;
    end else if (extent.ready) begin
      extent.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      extent.start_x    <= ends[0];
      extent.start_y    <= ends[1];
      extent.start_z    <= ends[2];
      extent.stop_x     <= ends[3];
      extent.stop_y     <= ends[4];
      extent.stop_z     <= ends[5];
      extent.degenerate <= dir_stat.zero_length;
    end
  end
endmodule
`default_nettype wire
